@@ src/md5sh_pkg.sv @@
// ---------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round helper functions for the MD5 stream core.
// ---------------------------------------------------------------------------
package md5sh_pkg;

	localparam int unsigned BLK_BYTES = 64;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS    = 64;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// fill position where the 64-bit length field starts
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] FILL_END = 6'd63;
	localparam logic [1:0] WIDX_END = 2'd3;

	typedef enum logic [2:0] {
		ST_IN,    // taking message bytes
		ST_PAD,   // pushing 0x80, zeros and length
		ST_COMP,  // 64 rounds over the block buffer
		ST_ADD,   // fold working words into the chain
		ST_OUT    // deliver four digest words
	} state_t;

	// control from the sequencer to the round engine
	typedef struct packed {
		logic       load;   // load working words from chain
		logic       step;   // run one round with the memory word
		logic [5:0] idx;    // round number
	} rnd_ctrl_t;

	localparam logic [31:0] MD5_K [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// message word index used by round i
	function automatic logic [3:0] msg_sel(input logic [5:0] i);
		logic [3:0] lo;
		logic [3:0] g;
		lo = i[3:0];
		case (i[5:4])
			2'd0: g = lo;
			2'd1: g = 4'((lo << 2) + lo + 4'd1);
			2'd2: g = 4'((lo << 1) + lo + 4'd5);
			2'd3: g = 4'((lo << 3) - lo);
			default: g = lo;
		endcase
		return g;
	endfunction

	// left-rotate amount of round i
	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
			4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
			4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
			4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

endpackage

@@ src/md5sh_buf.sv @@
// ---------------------------------------------------------------------------
// md5sh_buf
// 64-byte block buffer: byte-lane writes, 32-bit little-endian word reads.
// ---------------------------------------------------------------------------
module md5sh_buf (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_addr,   // byte address
	input  logic [7:0]  wr_data,
	input  logic        rd_en,
	input  logic [3:0]  rd_addr,   // word address
	output logic [31:0] rd_data
);

	logic [3:0][7:0] mem [md5sh_pkg::BLK_WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/md5sh_round.sv @@
// ---------------------------------------------------------------------------
// md5sh_round
// MD5 round engine: four working words, one round per step.
// ---------------------------------------------------------------------------
module md5sh_round (
	input  logic                  clk,
	input  md5sh_pkg::rnd_ctrl_t  ctrl,
	input  logic [3:0][31:0]      chain,   // [0]=A .. [3]=D
	input  logic [31:0]           msg,
	output logic [3:0][31:0]      work
);

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] rot;
	logic [31:0] t;

	always_comb begin
		case (ctrl.idx[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		sum = a_q + f + md5sh_pkg::MD5_K[ctrl.idx] + msg;
		rot = {sum, sum} << md5sh_pkg::rot_amt(ctrl.idx);
		t   = b_q + rot[63:32];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
		end else if (ctrl.step) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= t;
		end
	end

	assign work = {d_q, c_q, b_q, a_q};

endmodule

@@ src/md5sh_ctrl.sv @@
// ---------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: byte intake, padding, round issue, chaining and digest output.
// ---------------------------------------------------------------------------
module md5sh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_byte,
	input  logic                  s_valid_byte,
	input  logic                  s_eom,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_word,
	output logic [1:0]            m_index,
	output logic                  m_last,
	// block buffer
	output logic                  buf_wr_en,
	output logic [5:0]            buf_wr_addr,
	output logic [7:0]            buf_wr_data,
	output logic                  buf_rd_en,
	output logic [3:0]            buf_rd_addr,
	// round engine
	output md5sh_pkg::rnd_ctrl_t  rnd,
	output logic [3:0][31:0]      chain,
	input  logic [3:0][31:0]      work
);

	md5sh_pkg::state_t st_q, st_d;

	logic [5:0]       fill_q;
	logic [63:0]      bits_q;
	logic [3:0][31:0] chain_q;
	logic             pad_q;      // message finishing
	logic             sent80_q;   // 0x80 marker pushed
	logic             lenph_q;    // length field started
	logic [6:0]       rcnt_q;     // rounds issued to memory
	logic             step_s1;
	logic [5:0]       idx_s1;
	logic [1:0]       widx_q;

	logic       in_acc, out_acc, push, blk_full, pad_in_len, rd_issue, last_round;
	logic [7:0] push_byte;

	// ---------------- outputs / datapath controls ----------------
	always_comb begin
		s_tready   = (st_q == md5sh_pkg::ST_IN);
		in_acc     = s_tvalid && s_tready;
		m_tvalid   = (st_q == md5sh_pkg::ST_OUT);
		out_acc    = m_tvalid && m_tready;
		pad_in_len = sent80_q && (lenph_q || fill_q == md5sh_pkg::LEN_POS);
		push       = (in_acc && s_valid_byte) || (st_q == md5sh_pkg::ST_PAD);
		if (st_q != md5sh_pkg::ST_PAD) begin
			push_byte = s_byte;
		end else if (!sent80_q) begin
			push_byte = md5sh_pkg::PAD_BYTE;
		end else if (pad_in_len) begin
			push_byte = bits_q[{fill_q[2:0], 3'b000} +: 8];
		end else begin
			push_byte = 8'h00;
		end
		blk_full   = push && (fill_q == md5sh_pkg::FILL_END);
		rd_issue   = (st_q == md5sh_pkg::ST_COMP) && !rcnt_q[6];
		last_round = step_s1 && (idx_s1 == 6'(md5sh_pkg::ROUNDS - 1));
	end

	assign buf_wr_en   = push;
	assign buf_wr_addr = fill_q;
	assign buf_wr_data = push_byte;
	assign buf_rd_en   = rd_issue;
	assign buf_rd_addr = md5sh_pkg::msg_sel(rcnt_q[5:0]);

	assign rnd.load = blk_full;
	assign rnd.step = step_s1;
	assign rnd.idx  = idx_s1;
	assign chain    = chain_q;

	assign m_word  = chain_q[widx_q];
	assign m_index = widx_q;
	assign m_last  = (widx_q == md5sh_pkg::WIDX_END);

	// ---------------- next state ----------------
	always_comb begin
		st_d = st_q;
		case (st_q)
			md5sh_pkg::ST_IN: begin
				if (in_acc) begin
					if (blk_full) begin
						st_d = md5sh_pkg::ST_COMP;
					end else if (s_eom) begin
						st_d = md5sh_pkg::ST_PAD;
					end
				end
			end
			md5sh_pkg::ST_PAD: begin
				if (blk_full) begin
					st_d = md5sh_pkg::ST_COMP;
				end
			end
			md5sh_pkg::ST_COMP: begin
				if (last_round) begin
					st_d = md5sh_pkg::ST_ADD;
				end
			end
			md5sh_pkg::ST_ADD: begin
				if (lenph_q) begin
					st_d = md5sh_pkg::ST_OUT;
				end else if (pad_q) begin
					st_d = md5sh_pkg::ST_PAD;
				end else begin
					st_d = md5sh_pkg::ST_IN;
				end
			end
			md5sh_pkg::ST_OUT: begin
				if (out_acc && m_last) begin
					st_d = md5sh_pkg::ST_IN;
				end
			end
			default: st_d = md5sh_pkg::ST_IN;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= md5sh_pkg::ST_IN;
			fill_q   <= '0;
			bits_q   <= '0;
			chain_q  <= {md5sh_pkg::IV_D, md5sh_pkg::IV_C, md5sh_pkg::IV_B, md5sh_pkg::IV_A};
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			lenph_q  <= 1'b0;
			rcnt_q   <= '0;
			step_s1  <= 1'b0;
			idx_s1   <= '0;
			widx_q   <= '0;
		end else begin
			st_q    <= st_d;
			step_s1 <= rd_issue;
			idx_s1  <= rcnt_q[5:0];
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_acc && s_valid_byte) begin
				bits_q <= bits_q + 64'd8;
			end
			if (in_acc && s_eom) begin
				pad_q <= 1'b1;
			end
			if (st_q == md5sh_pkg::ST_PAD) begin
				sent80_q <= 1'b1;
				if (pad_in_len) begin
					lenph_q <= 1'b1;
				end
			end
			if (blk_full) begin
				rcnt_q <= '0;
			end else if (rd_issue) begin
				rcnt_q <= rcnt_q + 7'd1;
			end
			if (st_q == md5sh_pkg::ST_ADD) begin
				for (int k = 0; k < 4; k++) begin
					chain_q[k] <= chain_q[k] + work[k];
				end
			end
			if (out_acc) begin
				widx_q <= widx_q + 2'd1;
				if (m_last) begin
					chain_q  <= {md5sh_pkg::IV_D, md5sh_pkg::IV_C,
					             md5sh_pkg::IV_B, md5sh_pkg::IV_A};
					fill_q   <= '0;
					bits_q   <= '0;
					pad_q    <= 1'b0;
					sent80_q <= 1'b0;
					lenph_q  <= 1'b0;
				end
			end
		end
	end

	// ---------------- assertions ----------------
	// a round is only computed while the sequencer is in the round state
	a_step_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1 |-> (st_q == md5sh_pkg::ST_COMP))
		else $error("round step outside compression");

	// buffer never written while rounds read it
	a_no_wr_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == md5sh_pkg::ST_COMP) |-> !buf_wr_en)
		else $error("buffer write during compression");

	// every block compression starts with the fill count wrapped to zero and a fresh round count
	a_comp_entry: assert property (@(posedge clk) disable iff (!arst_n)
		blk_full |=> (fill_q == 6'd0) && (rcnt_q == 7'd0))
		else $error("bad compression start");

	// digest output only after the length field was written
	a_out_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lenph_q && fill_q == 6'd0))
		else $error("digest before length padding");

endmodule

@@ src/md5_stream_hash_core.sv @@
// ---------------------------------------------------------------------------
// md5_stream_hash_core
// Streaming MD5: one message byte per request, 128-bit digest as 4 words.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while a block fills; every 64th byte stalls
//   intake for a compression (a first word read, then 64 rounds at one per
//   cycle through the single block-buffer read port, then a chaining add).
// End of message: padding is pushed one byte per cycle, each padded block
//   then compressed (one or two in all), then four digest words, one per accepted cycle.
// Reset (arst_n low, async): chain at the MD5 initial vector, buffer empty,
//   bit count zero; buffer contents are not cleared and need not be.
// ---------------------------------------------------------------------------
module md5_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // end_of_message
	// digest stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word (digest byte 4k in [7:0])
	output logic [1:0]  m_tuser,   // [1:0] word_index
	output logic        m_tlast    // last_word
);

	// block buffer ports
	logic        buf_wr_en;
	logic [5:0]  buf_wr_addr;
	logic [7:0]  buf_wr_data;
	logic        buf_rd_en;
	logic [3:0]  buf_rd_addr;
	logic [31:0] buf_rd_data;

	// round engine
	md5sh_pkg::rnd_ctrl_t rnd;
	logic [3:0][31:0]     chain;
	logic [3:0][31:0]     work;

	// sequencer: owns fill count, bit count and chaining words
	md5sh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_byte       (s_tdata),
		.s_valid_byte (s_tuser),
		.s_eom        (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_word       (m_tdata),
		.m_index      (m_tuser),
		.m_last       (m_tlast),
		.buf_wr_en    (buf_wr_en),
		.buf_wr_addr  (buf_wr_addr),
		.buf_wr_data  (buf_wr_data),
		.buf_rd_en    (buf_rd_en),
		.buf_rd_addr  (buf_rd_addr),
		.rnd          (rnd),
		.chain        (chain),
		.work         (work)
	);

	// 64-byte block memory, registered word read
	md5sh_buf u_buf (
		.clk     (clk),
		.wr_en   (buf_wr_en),
		.wr_addr (buf_wr_addr),
		.wr_data (buf_wr_data),
		.rd_en   (buf_rd_en),
		.rd_addr (buf_rd_addr),
		.rd_data (buf_rd_data)
	);

	// round i consumes the word read in the cycle before it
	md5sh_round u_round (
		.clk   (clk),
		.ctrl  (rnd),
		.chain (chain),
		.msg   (buf_rd_data),
		.work  (work)
	);

	// intake and digest delivery never overlap
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("intake open while digest pending");

	// a digest word waiting for the sink stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("digest word changed while stalled");

	// the end-of-message request is followed by no intake until the digest is out
	a_eom_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("intake reopened before digest");

endmodule
